>>> hw/rtl/mefsd_pkg.sv
`timescale 1ns / 1ps
package mefsd_pkg;

  localparam int QueueSlots = 256;
  localparam int PtrW = 8;
  localparam int DrainMax = 64;
  localparam int ScrW = 6;
  localparam int EvW = 56;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_NOFF  = 3'd4,
    CMD_SOFF  = 3'd5,
    CMD_DRAIN = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  // One event as stored: offset in the low bits.
  typedef struct packed {
    logic [7:0]  data2;
    logic [7:0]  data1;
    logic [7:0]  status;
    logic [31:0] delta;
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BURST,
    ST_PEEKRD,
    ST_DPOP,
    ST_DCMP,
    ST_DPLACE,
    ST_EMIT_RD,
    ST_EMIT,
    ST_RESULT
  } state_t;

  // Result word handed to the output register.
  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    event_t     ev;
    logic       last;
  } result_t;

  // Signed compare of two offsets.
  function automatic logic delta_less(input logic [31:0] a, input logic [31:0] b);
    delta_less = $signed(a) < $signed(b);
  endfunction

endpackage

>>> hw/rtl/mefsd_ram.sv
`timescale 1ns / 1ps
module mefsd_ram #(
  parameter int Depth = 256,
  parameter int AddrW = 8,
  parameter int DataW = 56
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/midi_event_fifo_sorted_drain.sv
`timescale 1ns / 1ps
// MIDI event queue with stable sorted drain.
// Input channel s_axis: one command a transfer. Output channel m_axis: the
// results of that command, tlast on the final one. Exactly one result per
// command, except a drain that removes n > 0 events, which gives n results
// in ascending signed offset order, equal offsets in queue order.
// A drain pops each event into a 64-entry scratch memory and sorts it in
// by insertion, one compare or shift a cycle, shifting each larger entry
// up by one slot; it then reads the sorted entries back in order and hands
// each to the output register as one result. One command is worked at a
// time; tready on s_axis is high only when idle.
// Reset clears both pointers and the controller; the memories keep their
// content and need no clearing pass. If the receiver stalls, the result
// holds in the output register and the controller waits.
module midi_event_fifo_sorted_drain (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: command[2:0], in_delta[34:3], in_status[42:35], in_data1[50:43],
  // in_data2[58:51], drain_limit[65:59], zero fill to 72 bits
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: accepted[0], out_valid[1], out_delta[33:2], out_status[41:34],
  // out_data1[49:42], out_data2[57:50], occupancy[65:58], is_empty[66],
  // is_full[67], zero fill to 72 bits
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  import mefsd_pkg::*;

  state_t state, state_next;
  cmd_t cmd;
  logic [PtrW-1:0] wp, rp;
  logic [6:0] limit;
  logic [6:0] n;
  logic [ScrW-1:0] j;
  logic [4:0] bcnt;
  logic bok;
  event_t cur;
  logic [6:0] ecnt;

  logic q_empty, q_full;
  assign q_empty = (rp == wp);
  assign q_full = (PtrW'(wp + 1'b1) == rp);

  // Event store.
  logic ev_we;
  logic [PtrW-1:0] ev_wa, ev_ra;
  event_t ev_wd, ev_rd;
  mefsd_ram #(.Depth(QueueSlots), .AddrW(PtrW), .DataW(EvW)) u_store (
    .clk(clk), .we(ev_we), .waddr(ev_wa), .wdata(ev_wd),
    .raddr(ev_ra), .rdata(ev_rd)
  );

  // Drain scratch.
  logic sc_we;
  logic [ScrW-1:0] sc_wa, sc_ra;
  event_t sc_wd, sc_rd;
  mefsd_ram #(.Depth(DrainMax), .AddrW(ScrW), .DataW(EvW)) u_scratch (
    .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd),
    .raddr(sc_ra), .rdata(sc_rd)
  );

  logic out_full;
  result_t res;
  logic res_go;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_axis_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (cmd)
          CMD_PEEK:  state_next = q_empty ? ST_RESULT : ST_PEEKRD;
          CMD_NOFF, CMD_SOFF: state_next = ST_BURST;
          CMD_DRAIN: state_next = (limit == 7'd0 || q_empty) ? ST_RESULT : ST_DPOP;
          CMD_POP:   state_next = q_empty ? ST_RESULT : ST_PEEKRD;
          default:   state_next = ST_RESULT;
        endcase
      end
      ST_BURST:   if (bcnt == 5'd15) state_next = ST_RESULT;
      ST_PEEKRD:  state_next = ST_RESULT;
      ST_DPOP:    state_next = (n == 7'd0) ? ST_DPLACE : ST_DCMP;
      ST_DCMP: begin
        if (!delta_less(cur.delta, sc_rd.delta) || j == '0) state_next = ST_DPLACE;
      end
      ST_DPLACE: begin
        if (PtrW'(rp) == wp || 7'(n + 1'b1) == limit) state_next = ST_EMIT_RD;
        else state_next = ST_DPOP;
      end
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT:    if (!out_full || m_axis_tready) state_next =
                    (7'(ecnt + 1'b1) == n) ? ST_IDLE : ST_EMIT_RD;
      ST_RESULT:  if (!out_full || m_axis_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory and result controls.
  always_comb begin
    ev_we = 1'b0;
    ev_wa = wp;
    ev_wd = '0;
    ev_ra = rp;
    sc_we = 1'b0;
    sc_wa = j;
    sc_wd = cur;
    sc_ra = ScrW'(j - 1'b1);
    res_go = 1'b0;
    res = '0;
    case (state)
      ST_EXEC: begin
        if (cmd == CMD_PUSH && !q_full) begin
          ev_we = 1'b1;
        end
        ev_wd = cur;
      end
      ST_BURST: begin
        ev_we = !q_full;
        ev_wd = '{data2: 8'd0, data1: (cmd == CMD_NOFF) ? 8'd123 : 8'd120,
                  status: {4'hB, bcnt[3:0]}, delta: 32'd0};
      end
      // Fetch the last sorted entry for the first compare.
      ST_DPOP: sc_ra = ScrW'(n[ScrW-1:0] - 1'b1);
      ST_DCMP: begin
        if (delta_less(cur.delta, sc_rd.delta) && j != '0) begin
          sc_we = 1'b1;
          sc_wd = sc_rd;
          sc_ra = ScrW'(j - 2'd2);
        end
      end
      ST_DPLACE: sc_we = 1'b1;
      ST_EMIT_RD: sc_ra = ecnt[ScrW-1:0];
      ST_EMIT: begin
        sc_ra = ecnt[ScrW-1:0];
        res_go = 1'b1;
        res.out_valid = 1'b1;
        res.ev = sc_rd;
        res.last = (7'(ecnt + 1'b1) == n);
      end
      ST_RESULT: begin
        res_go = 1'b1;
        res.last = 1'b1;
        res.accepted = (cmd == CMD_PUSH) ? bok :
                       (cmd == CMD_NOFF || cmd == CMD_SOFF) ? bok : 1'b0;
        res.out_valid = (cmd == CMD_POP || cmd == CMD_PEEK) && bok;
        res.ev = res.out_valid ? cur : '0;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp <= '0;
      rp <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          cmd <= cmd_t'(s_axis_tdata[2:0]);
          limit <= (s_axis_tdata[65:59] > 7'(DrainMax)) ? 7'(DrainMax)
                                                        : s_axis_tdata[65:59];
          cur <= s_axis_tdata[58:3];
          bcnt <= '0;
          bok <= 1'b1;
          n <= '0;
          ecnt <= '0;
        end
        ST_EXEC: begin
          case (cmd)
            CMD_PUSH: begin
              bok <= !q_full;
              if (!q_full) wp <= PtrW'(wp + 1'b1);
            end
            CMD_POP: begin
              bok <= !q_empty;
              if (!q_empty) rp <= PtrW'(rp + 1'b1);
            end
            CMD_PEEK: bok <= !q_empty;
            CMD_CLEAR: rp <= wp;
            default: ;
          endcase
        end
        ST_BURST: begin
          bcnt <= 5'(bcnt + 1'b1);
          if (q_full) bok <= 1'b0;
          else wp <= PtrW'(wp + 1'b1);
        end
        ST_PEEKRD: cur <= ev_rd;
        ST_DPOP: begin
          cur <= ev_rd;
          rp <= PtrW'(rp + 1'b1);
          j <= n[ScrW-1:0];
        end
        ST_DCMP: begin
          if (delta_less(cur.delta, sc_rd.delta) && j != '0) j <= ScrW'(j - 1'b1);
        end
        ST_DPLACE: n <= 7'(n + 1'b1);
        ST_EMIT: if (!out_full || m_axis_tready) ecnt <= 7'(ecnt + 1'b1);
        default: ;
      endcase
    end
  end

  // Occupancy after the command, from the pointers.
  logic [PtrW-1:0] occ;
  assign occ = PtrW'(wp - rp);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_go && (!out_full || m_axis_tready)) begin
      out_full <= 1'b1;
      m_axis_tdata <= {4'd0, q_full, q_empty, 8'(occ), res.ev.data2, res.ev.data1,
                       res.ev.status, res.ev.delta, res.out_valid, res.accepted};
      m_axis_tlast <= res.last;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_full;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !res_go) else $error("result while idle");
  a_scr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DPLACE) |-> (n < 7'(DrainMax))) else $error("scratch overrun");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ev_we |-> !q_full) else $error("write into full queue");

endmodule
